// ----- design/r2h_pkg.sv -----
`default_nettype none

package r2h_pkg;

   localparam int DEFAULT_CHANNEL_BITS  = 8;
   localparam int DEFAULT_FRACTION_BITS = 16;

   // Which formula the hue numerator uses, taken from the largest channel.
   typedef logic [1:0] hue_sel_type;

   localparam hue_sel_type SEL_RED_UP   = 2'd0;
   localparam hue_sel_type SEL_RED_DOWN = 2'd1;
   localparam hue_sel_type SEL_GREEN    = 2'd2;
   localparam hue_sel_type SEL_BLUE     = 2'd3;

endpackage

`default_nettype wire

// ----- design/r2h_if.sv -----
`default_nettype none

interface r2h_pixel_if #(
   parameter int CHANNEL_BITS = r2h_pkg::DEFAULT_CHANNEL_BITS
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface r2h_hsv_if #(
   parameter int CHANNEL_BITS  = r2h_pkg::DEFAULT_CHANNEL_BITS,
   parameter int FRACTION_BITS = r2h_pkg::DEFAULT_FRACTION_BITS
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS-1:0] hue;
   logic [FRACTION_BITS-1:0] saturation;
   logic [CHANNEL_BITS-1:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

`default_nettype wire

// ----- design/rgb_to_hsv_converter_top.sv -----
// Stages from an accepted pixel to its result beat: two front stages, one stage per quotient bit,
// one output register. Throughput: one pixel per cycle while the skid register is empty.
// Each divider stage resolves one bit of hue and saturation.
// A stalled output parks one beat in a skid register and then holds the pipeline.
// Reset (synchronous, active high) clears the valid bits only; no clearing pass.
`default_nettype none

module rgb_to_hsv_converter_top #(
   parameter int CHANNEL_BITS  = r2h_pkg::DEFAULT_CHANNEL_BITS,
   parameter int FRACTION_BITS = r2h_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic      clock,
   input  logic      reset,
   r2h_pixel_if.sink req,
   r2h_hsv_if.source rsp
);

   localparam int DEN_W = CHANNEL_BITS + 3;

   logic                     enable;
   logic                     valid      [0:FRACTION_BITS];
   logic [DEN_W-1:0]         hue_den    [0:FRACTION_BITS];
   logic [DEN_W-1:0]         hue_rem    [0:FRACTION_BITS];
   logic [FRACTION_BITS-1:0] hue_acc    [0:FRACTION_BITS];
   logic [CHANNEL_BITS-1:0]  sat_den    [0:FRACTION_BITS];
   logic [CHANNEL_BITS-1:0]  sat_rem    [0:FRACTION_BITS];
   logic [FRACTION_BITS-1:0] sat_acc    [0:FRACTION_BITS];
   logic [CHANNEL_BITS-1:0]  bright     [0:FRACTION_BITS];

   assign req.ready = enable;

   r2h_front #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .up_valid   (req.valid),
      .up_red     (req.red),
      .up_green   (req.green),
      .up_blue    (req.blue),
      .dn_valid   (valid[0]),
      .dn_hue_den (hue_den[0]),
      .dn_hue_rem (hue_rem[0]),
      .dn_hue_acc (hue_acc[0]),
      .dn_sat_den (sat_den[0]),
      .dn_sat_rem (sat_rem[0]),
      .dn_sat_acc (sat_acc[0]),
      .dn_bright  (bright[0])
   );

   for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
      r2h_div_stage #(
         .CHANNEL_BITS  (CHANNEL_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .up_valid   (valid[k]),
         .up_hue_den (hue_den[k]),
         .up_hue_rem (hue_rem[k]),
         .up_hue_acc (hue_acc[k]),
         .up_sat_den (sat_den[k]),
         .up_sat_rem (sat_rem[k]),
         .up_sat_acc (sat_acc[k]),
         .up_bright  (bright[k]),
         .dn_valid   (valid[k+1]),
         .dn_hue_den (hue_den[k+1]),
         .dn_hue_rem (hue_rem[k+1]),
         .dn_hue_acc (hue_acc[k+1]),
         .dn_sat_den (sat_den[k+1]),
         .dn_sat_rem (sat_rem[k+1]),
         .dn_sat_acc (sat_acc[k+1]),
         .dn_bright  (bright[k+1])
      );
   end

   r2h_out_buf #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (valid[FRACTION_BITS]),
      .up_hue    (hue_acc[FRACTION_BITS]),
      .up_sat    (sat_acc[FRACTION_BITS]),
      .up_bright (bright[FRACTION_BITS]),
      .enable    (enable),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ----- design/r2h_front.sv -----
`default_nettype none

module r2h_front #(
   parameter int CHANNEL_BITS  = r2h_pkg::DEFAULT_CHANNEL_BITS,
   parameter int FRACTION_BITS = r2h_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  up_valid,
   input  logic [CHANNEL_BITS-1:0]               up_red,
   input  logic [CHANNEL_BITS-1:0]               up_green,
   input  logic [CHANNEL_BITS-1:0]               up_blue,
   output logic                                  dn_valid,
   output logic [CHANNEL_BITS+2:0]               dn_hue_den,
   output logic [CHANNEL_BITS+2:0]               dn_hue_rem,
   output logic [FRACTION_BITS-1:0]              dn_hue_acc,
   output logic [CHANNEL_BITS-1:0]               dn_sat_den,
   output logic [CHANNEL_BITS-1:0]               dn_sat_rem,
   output logic [FRACTION_BITS-1:0]              dn_sat_acc,
   output logic [CHANNEL_BITS-1:0]               dn_bright
);
   import r2h_pkg::*;

   localparam int DEN_W = CHANNEL_BITS + 3;
   localparam int NUM_W = CHANNEL_BITS + FRACTION_BITS;

   logic                    a_valid_ff;
   logic [CHANNEL_BITS-1:0] a_red_ff;
   logic [CHANNEL_BITS-1:0] a_green_ff;
   logic [CHANNEL_BITS-1:0] a_blue_ff;
   logic [CHANNEL_BITS-1:0] a_hi_ff;
   logic [CHANNEL_BITS-1:0] a_lo_ff;
   hue_sel_type             a_sel_ff;
   logic [CHANNEL_BITS-1:0] a_hi_in;
   logic [CHANNEL_BITS-1:0] a_lo_in;
   hue_sel_type             a_sel_in;

   logic                     b_valid_ff;
   logic [DEN_W-1:0]         b_hue_den_ff;
   logic [DEN_W-1:0]         b_hue_rem_ff;
   logic [CHANNEL_BITS-1:0]  b_sat_den_ff;
   logic [CHANNEL_BITS-1:0]  b_sat_rem_ff;
   logic [FRACTION_BITS-1:0] b_sat_acc_ff;
   logic [CHANNEL_BITS-1:0]  b_bright_ff;
   logic [DEN_W-1:0]         b_hue_den_in;
   logic [DEN_W-1:0]         b_hue_rem_in;
   logic [CHANNEL_BITS-1:0]  b_sat_den_in;
   logic [CHANNEL_BITS-1:0]  b_sat_rem_in;
   logic [FRACTION_BITS-1:0] b_sat_acc_in;

   logic [CHANNEL_BITS-1:0] diff;
   logic [DEN_W-1:0]        d_ext;
   logic [DEN_W-1:0]        r_ext;
   logic [DEN_W-1:0]        g_ext;
   logic [DEN_W-1:0]        b_ext;
   logic [DEN_W-1:0]        six_d;
   logic [DEN_W-1:0]        hue_num;
   logic [NUM_W-1:0]        sat_num;
   logic                    gray;

   always_comb begin
      a_hi_in = up_red;
      if (up_green > a_hi_in) begin
         a_hi_in = up_green;
      end
      if (up_blue > a_hi_in) begin
         a_hi_in = up_blue;
      end
      a_lo_in = up_red;
      if (up_green < a_lo_in) begin
         a_lo_in = up_green;
      end
      if (up_blue < a_lo_in) begin
         a_lo_in = up_blue;
      end
      if (up_red >= up_green && up_red >= up_blue) begin
         a_sel_in = (up_green >= up_blue) ? SEL_RED_UP : SEL_RED_DOWN;
      end else if (up_green >= up_blue) begin
         a_sel_in = SEL_GREEN;
      end else begin
         a_sel_in = SEL_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_red_ff   <= up_red;
         a_green_ff <= up_green;
         a_blue_ff  <= up_blue;
         a_hi_ff    <= a_hi_in;
         a_lo_ff    <= a_lo_in;
         a_sel_ff   <= a_sel_in;
      end
   end

   assign diff  = a_hi_ff - a_lo_ff;
   assign d_ext = {3'b000, diff};
   assign r_ext = {3'b000, a_red_ff};
   assign g_ext = {3'b000, a_green_ff};
   assign b_ext = {3'b000, a_blue_ff};
   assign six_d = (d_ext << 2) + (d_ext << 1);
   assign gray  = (diff == '0);

   always_comb begin
      case (a_sel_ff)
         SEL_RED_UP:   hue_num = g_ext - b_ext;
         SEL_RED_DOWN: hue_num = (six_d + g_ext) - b_ext;
         SEL_GREEN:    hue_num = ((d_ext << 1) + b_ext) - r_ext;
         SEL_BLUE:     hue_num = ((d_ext << 2) + r_ext) - g_ext;
         default:      hue_num = '0;
      endcase
   end

   // d * (2^F - 1), formed as a shift and one subtract.
   assign sat_num = {diff, {FRACTION_BITS{1'b0}}} - {{FRACTION_BITS{1'b0}}, diff};

   // A gray pixel divides zero by one, which yields zero hue and saturation.
   always_comb begin
      if (gray) begin
         b_hue_den_in = DEN_W'(1);
         b_hue_rem_in = '0;
         b_sat_den_in = CHANNEL_BITS'(1);
         b_sat_rem_in = '0;
         b_sat_acc_in = '0;
      end else begin
         b_hue_den_in = six_d;
         b_hue_rem_in = hue_num;
         b_sat_den_in = a_hi_ff;
         b_sat_rem_in = sat_num[NUM_W-1:FRACTION_BITS];
         b_sat_acc_in = sat_num[FRACTION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_hue_den_ff <= b_hue_den_in;
         b_hue_rem_ff <= b_hue_rem_in;
         b_sat_den_ff <= b_sat_den_in;
         b_sat_rem_ff <= b_sat_rem_in;
         b_sat_acc_ff <= b_sat_acc_in;
         b_bright_ff  <= a_hi_ff;
      end
   end

   assign dn_valid   = b_valid_ff;
   assign dn_hue_den = b_hue_den_ff;
   assign dn_hue_rem = b_hue_rem_ff;
   assign dn_hue_acc = '0;
   assign dn_sat_den = b_sat_den_ff;
   assign dn_sat_rem = b_sat_rem_ff;
   assign dn_sat_acc = b_sat_acc_ff;
   assign dn_bright  = b_bright_ff;

endmodule

`default_nettype wire

// ----- design/r2h_div_stage.sv -----
`default_nettype none

module r2h_div_stage #(
   parameter int CHANNEL_BITS  = r2h_pkg::DEFAULT_CHANNEL_BITS,
   parameter int FRACTION_BITS = r2h_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     up_valid,
   input  logic [CHANNEL_BITS+2:0]  up_hue_den,
   input  logic [CHANNEL_BITS+2:0]  up_hue_rem,
   input  logic [FRACTION_BITS-1:0] up_hue_acc,
   input  logic [CHANNEL_BITS-1:0]  up_sat_den,
   input  logic [CHANNEL_BITS-1:0]  up_sat_rem,
   input  logic [FRACTION_BITS-1:0] up_sat_acc,
   input  logic [CHANNEL_BITS-1:0]  up_bright,
   output logic                     dn_valid,
   output logic [CHANNEL_BITS+2:0]  dn_hue_den,
   output logic [CHANNEL_BITS+2:0]  dn_hue_rem,
   output logic [FRACTION_BITS-1:0] dn_hue_acc,
   output logic [CHANNEL_BITS-1:0]  dn_sat_den,
   output logic [CHANNEL_BITS-1:0]  dn_sat_rem,
   output logic [FRACTION_BITS-1:0] dn_sat_acc,
   output logic [CHANNEL_BITS-1:0]  dn_bright
);

   localparam int DEN_W = CHANNEL_BITS + 3;

   // The accumulator feeds dividend bits out at the top and takes quotient
   // bits in at the bottom, so after all steps it holds the quotient.
   logic [DEN_W:0]           hue_trial;
   logic [DEN_W-1:0]         hue_diff;
   logic                     hue_fit;
   logic [CHANNEL_BITS:0]    sat_trial;
   logic [CHANNEL_BITS-1:0]  sat_diff;
   logic                     sat_fit;

   logic                     valid_ff;
   logic [DEN_W-1:0]         hue_den_ff;
   logic [DEN_W-1:0]         hue_rem_ff;
   logic [FRACTION_BITS-1:0] hue_acc_ff;
   logic [CHANNEL_BITS-1:0]  sat_den_ff;
   logic [CHANNEL_BITS-1:0]  sat_rem_ff;
   logic [FRACTION_BITS-1:0] sat_acc_ff;
   logic [CHANNEL_BITS-1:0]  bright_ff;
   logic [DEN_W-1:0]         hue_rem_in;
   logic [FRACTION_BITS-1:0] hue_acc_in;
   logic [CHANNEL_BITS-1:0]  sat_rem_in;
   logic [FRACTION_BITS-1:0] sat_acc_in;

   assign hue_trial  = {up_hue_rem, up_hue_acc[FRACTION_BITS-1]};
   assign hue_diff   = hue_trial[DEN_W-1:0] - up_hue_den;
   assign hue_fit    = hue_trial >= {1'b0, up_hue_den};
   assign hue_rem_in = hue_fit ? hue_diff : hue_trial[DEN_W-1:0];
   assign hue_acc_in = {up_hue_acc[FRACTION_BITS-2:0], hue_fit};

   assign sat_trial  = {up_sat_rem, up_sat_acc[FRACTION_BITS-1]};
   assign sat_diff   = sat_trial[CHANNEL_BITS-1:0] - up_sat_den;
   assign sat_fit    = sat_trial >= {1'b0, up_sat_den};
   assign sat_rem_in = sat_fit ? sat_diff : sat_trial[CHANNEL_BITS-1:0];
   assign sat_acc_in = {up_sat_acc[FRACTION_BITS-2:0], sat_fit};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hue_den_ff <= up_hue_den;
         hue_rem_ff <= hue_rem_in;
         hue_acc_ff <= hue_acc_in;
         sat_den_ff <= up_sat_den;
         sat_rem_ff <= sat_rem_in;
         sat_acc_ff <= sat_acc_in;
         bright_ff  <= up_bright;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_hue_den = hue_den_ff;
   assign dn_hue_rem = hue_rem_ff;
   assign dn_hue_acc = hue_acc_ff;
   assign dn_sat_den = sat_den_ff;
   assign dn_sat_rem = sat_rem_ff;
   assign dn_sat_acc = sat_acc_ff;
   assign dn_bright  = bright_ff;

endmodule

`default_nettype wire

// ----- design/r2h_out_buf.sv -----
`default_nettype none

module r2h_out_buf #(
   parameter int CHANNEL_BITS  = r2h_pkg::DEFAULT_CHANNEL_BITS,
   parameter int FRACTION_BITS = r2h_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   input  logic [FRACTION_BITS-1:0] up_hue,
   input  logic [FRACTION_BITS-1:0] up_sat,
   input  logic [CHANNEL_BITS-1:0]  up_bright,
   output logic                     enable,
   r2h_hsv_if.source                rsp
);

   logic                     push;
   logic                     out_free;

   logic                     out_valid_ff;
   logic [FRACTION_BITS-1:0] out_hue_ff;
   logic [FRACTION_BITS-1:0] out_sat_ff;
   logic [CHANNEL_BITS-1:0]  out_bright_ff;
   logic                     skid_valid_ff;
   logic [FRACTION_BITS-1:0] skid_hue_ff;
   logic [FRACTION_BITS-1:0] skid_sat_ff;
   logic [CHANNEL_BITS-1:0]  skid_bright_ff;

   logic                     out_valid_in;
   logic [FRACTION_BITS-1:0] out_hue_in;
   logic [FRACTION_BITS-1:0] out_sat_in;
   logic [CHANNEL_BITS-1:0]  out_bright_in;
   logic                     skid_valid_in;
   logic [FRACTION_BITS-1:0] skid_hue_in;
   logic [FRACTION_BITS-1:0] skid_sat_in;
   logic [CHANNEL_BITS-1:0]  skid_bright_in;

   // The pipeline advances only while the skid register is empty.
   assign enable   = !skid_valid_ff;
   assign push     = up_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_hue_in     = out_hue_ff;
      out_sat_in     = out_sat_ff;
      out_bright_in  = out_bright_ff;
      skid_valid_in  = skid_valid_ff;
      skid_hue_in    = skid_hue_ff;
      skid_sat_in    = skid_sat_ff;
      skid_bright_in = skid_bright_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_hue_in    = skid_hue_ff;
            out_sat_in    = skid_sat_ff;
            out_bright_in = skid_bright_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_hue_in    = up_hue;
            out_sat_in    = up_sat;
            out_bright_in = up_bright;
         end
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_hue_in    = up_hue;
         skid_sat_in    = up_sat;
         skid_bright_in = up_bright;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hue_ff     <= out_hue_in;
      out_sat_ff     <= out_sat_in;
      out_bright_ff  <= out_bright_in;
      skid_hue_ff    <= skid_hue_in;
      skid_sat_ff    <= skid_sat_in;
      skid_bright_ff <= skid_bright_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hue        = out_hue_ff;
   assign rsp.saturation = out_sat_ff;
   assign rsp.brightness = out_bright_ff;

`ifndef SYNTHESIS
   skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while the output register is empty");

   skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp.ready))
      else $error("skid register filled without a stalled output beat");

   black_has_no_saturation: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_bright_ff == '0) |-> (out_sat_ff == '0))
      else $error("black pixel produced nonzero saturation");
`endif

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsv_converter_top_test.sv -----
`timescale 1ns / 100ps

module rgb_to_hsv_converter_top_test;

   import r2h_pkg::*;

   localparam int CHANNEL_BITS  = DEFAULT_CHANNEL_BITS;
   localparam int FRACTION_BITS = DEFAULT_FRACTION_BITS;
   localparam int PIPE_LATENCY  = FRACTION_BITS + 3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PIXELS = 170;
   localparam int HOLD_CYCLES   = 150;

   typedef logic [CHANNEL_BITS-1:0]  channel_type;
   typedef logic [FRACTION_BITS-1:0] fraction_type;

   typedef struct packed {
      fraction_type hue;
      fraction_type saturation;
      channel_type  brightness;
   } hsv_type;

   class hsv_scoreboard;
      hsv_type expected_hsv[$];
      int      errors = 0;

      function void note_pixel(channel_type red, channel_type green, channel_type blue);
         longint unsigned r, g, b, hi, lo, d, num;
         hue_sel_type     sel;
         hsv_type         hsv;
         r  = red;
         g  = green;
         b  = blue;
         hi = r;
         lo = r;
         if (g > hi) hi = g;
         if (b > hi) hi = b;
         if (g < lo) lo = g;
         if (b < lo) lo = b;
         d = hi - lo;
         hsv.brightness = channel_type'(hi);
         hsv.saturation = (hi == 0) ? '0 : fraction_type'((d * ((64'd1 << FRACTION_BITS) - 1)) / hi);
         if (d == 0) begin
            hsv.hue = '0;
         end else begin
            if (r >= g && r >= b) begin
               sel = (g >= b) ? SEL_RED_UP : SEL_RED_DOWN;
            end else if (g >= b) begin
               sel = SEL_GREEN;
            end else begin
               sel = SEL_BLUE;
            end
            case (sel)
               SEL_RED_UP: begin
                  num = g - b;
               end
               SEL_RED_DOWN: begin
                  num = 6 * d - (b - g);
               end
               SEL_GREEN: begin
                  num = 2 * d + b - r;
               end
               default: begin
                  num = 4 * d + r - g;
               end
            endcase
            hsv.hue = fraction_type'((num << FRACTION_BITS) / (6 * d));
         end
         expected_hsv.push_back(hsv);
      endfunction

      function void check_hsv(hsv_type actual);
         hsv_type want;
         if (expected_hsv.size() == 0) begin
            $error("result beat with no pixel pending: hue %0d saturation %0d brightness %0d",
                   actual.hue, actual.saturation, actual.brightness);
            errors++;
            return;
         end
         want = expected_hsv.pop_front();
         if (actual.hue !== want.hue) begin
            $error("hue mismatch: expected %0d, actual %0d", want.hue, actual.hue);
            errors++;
         end
         if (actual.saturation !== want.saturation) begin
            $error("saturation mismatch: expected %0d, actual %0d",
                   want.saturation, actual.saturation);
            errors++;
         end
         if (actual.brightness !== want.brightness) begin
            $error("brightness mismatch: expected %0d, actual %0d",
                   want.brightness, actual.brightness);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;

   hsv_scoreboard pixel_board = new();

   r2h_pixel_if #(.CHANNEL_BITS(CHANNEL_BITS)) req_if ();
   r2h_hsv_if #(.CHANNEL_BITS(CHANNEL_BITS), .FRACTION_BITS(FRACTION_BITS)) rsp_if ();

   rgb_to_hsv_converter_top #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_pixel(input channel_type red, input channel_type green,
                             input channel_type blue);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.red   <= red;
      req_if.green <= green;
      req_if.blue  <= blue;
      do @(posedge clock); while (!req_if.ready);
      pixel_board.note_pixel(red, green, blue);
   endtask

   task automatic send_random_pixel();
      channel_type r, g, b, v, w;
      int          kind;
      kind = $urandom_range(9);
      r    = channel_type'($urandom_range(255));
      g    = channel_type'($urandom_range(255));
      b    = channel_type'($urandom_range(255));
      v    = channel_type'($urandom_range(255));
      w    = channel_type'($urandom_range(v));
      case (kind)
         0: begin
            r = v;
            g = v;
            b = v;
         end
         1: begin
            case ($urandom_range(2))
               0: begin r = v; g = v; b = w; end
               1: begin r = w; g = v; b = v; end
               default: begin r = v; g = w; b = v; end
            endcase
         end
         2: begin
            g = channel_type'((v > 253) ? v - $urandom_range(2) : v + $urandom_range(2));
            b = channel_type'((v < 2) ? v + $urandom_range(2) : v - $urandom_range(2));
            r = v;
         end
         default: begin
         end
      endcase
      send_pixel(r, g, b);
   endtask

   // Result side: checks each beat and drives ready, with one long hold-off
   // that lets the pipeline fill and back up into the input.
   initial begin
      int results_seen;
      int hold_left;
      bit hold_done;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            pixel_board.check_hsv('{rsp_if.hue, rsp_if.saturation, rsp_if.brightness});
            results_seen++;
         end
         if (!hold_done && results_seen == 60) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.red   <= '0;
      req_if.green <= '0;
      req_if.blue  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 63;

      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd1);
      send_pixel(8'd1, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd1);
      send_pixel(8'd1, 8'd1, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd200, 8'd100, 8'd150);
      send_pixel(8'd170, 8'd85, 8'd0);
      send_pixel(8'd3, 8'd2, 8'd1);

      repeat (RANDOM_PIXELS) send_random_pixel();

      send_idle_pct = 63;
      recv_idle_pct = 26;
      repeat (RANDOM_PIXELS) send_random_pixel();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (RANDOM_PIXELS) send_random_pixel();
      req_if.valid <= 1'b0;

      while (pixel_board.expected_hsv.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 6) @(posedge clock);

      if (pixel_board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/r2h_pkg.sv
design/r2h_if.sv
design/r2h_front.sv
design/r2h_div_stage.sv
design/r2h_out_buf.sv
design/rgb_to_hsv_converter_top.sv
sim/rgb_to_hsv_converter_top_test.sv
